// ----- hw/rtl/gttr_pkg.sv -----
// Shared types and codes for the generation-tagged task ring.
`default_nettype none
package gttr_pkg;

   localparam logic [1:0] MODE_PUSH     = 2'd0;
   localparam logic [1:0] MODE_POP      = 2'd1;
   localparam logic [1:0] MODE_COMPLETE = 2'd2;
   localparam logic [1:0] MODE_QUERY    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] task_code;
      logic [31:0] task_argument;
      logic [7:0]  slot_index;
      logic [15:0] ticket;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  out_slot;
      logic [15:0] out_ticket;
      logic [31:0] out_code;
      logic [31:0] out_argument;
      logic        is_done;
   } rsp_type;

   typedef struct packed {
      req_type beat;
      logic    in_range;
   } entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/generation_tagged_task_ring.sv -----
// Top level of the generation-tagged task ring: front queue plus back sequencer.
// A request beat passes the front queue, then the RAM read with the beat held (ST_EVAL), then the response register.
// The back takes no new beat until the last has left ST_EVAL, as set by the read-then-write of the generation RAM.
// A 2-entry queue lets the front keep taking beats while the back or response stalls.
// Reset: synchronous; then a clear sweep over all QUEUE_DEPTH slots loads generation i
// into slot i, with req_stall held high until it ends.
`default_nettype none
module generation_tagged_task_ring
   import gttr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic      clearing;
   logic      entry_valid;
   logic      entry_take;
   entry_type entry;

   gttr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .clearing    (clearing),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_take  (entry_take)
   );

   gttr_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_take  (entry_take),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request taken during clear sweep");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("back-to-back response beats");

   a_take_when_valid: assert property (@(posedge clock) disable iff (reset)
      entry_take |-> (entry_valid && !clearing))
      else $error("queue read while empty or clearing");

endmodule
`default_nettype wire

// ----- hw/rtl/gttr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gttr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/gttr_front.sv -----
// Front end: accepts request beats, range-checks the slot and queues them.
`default_nettype none
module gttr_front
   import gttr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_data,
   input  wire logic      clearing,
   output logic           entry_valid,
   output entry_type      entry,
   input  wire logic      entry_take
);

   entry_type  q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   entry_type  incoming;

   assign req_stall = clearing || (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = entry_take && (count_ff != 2'd0);

   always_comb begin
      incoming.beat     = req_data;
      incoming.in_range = (32'(req_data.slot_index) < 32'(QUEUE_DEPTH));
   end

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= incoming;
      end
   end

   assign entry_valid = (count_ff != 2'd0);
   assign entry       = q_ff[rptr_ff];

endmodule
`default_nettype wire

// ----- hw/rtl/gttr_back.sv -----
// Back end: slot memories, head/tail counters, clear sweep and result register.
`default_nettype none
module gttr_back
   import gttr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      entry_valid,
   input  wire entry_type entry,
   output logic           entry_take,
   output logic           clearing,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   localparam int             AW      = $clog2(QUEUE_DEPTH);
   localparam logic [AW-1:0]  LAST    = AW'(QUEUE_DEPTH - 1);
   localparam logic [15:0]    GEN_LAP = 16'(QUEUE_DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [15:0]   head_ff, head_in;
   logic [15:0]   tail_ff, tail_in;
   logic [AW-1:0] hslot_ff, hslot_in;
   logic [AW-1:0] tslot_ff, tslot_in;
   entry_type     cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          issue;
   logic [AW-1:0] rd_addr;
   logic          gen_we;
   logic [AW-1:0] gen_waddr;
   logic [15:0]   gen_wdata;
   logic [15:0]   gen_rdata;
   logic          pay_we;
   logic [63:0]   pay_rdata;
   logic [15:0]   head_next, tail_next;
   logic [AW-1:0] cur_slot;

   assign clearing   = (state_ff == ST_CLEAR);
   assign issue      = (state_ff == ST_IDLE) && entry_valid && (!rsp_valid_ff || !rsp_stall);
   assign entry_take = issue;
   assign head_next  = head_ff + 16'd1;
   assign tail_next  = tail_ff + 16'd1;
   assign cur_slot   = AW'(cur_ff.beat.slot_index);

   always_comb begin
      unique case (entry.beat.mode)
         MODE_PUSH: rd_addr = hslot_ff;
         MODE_POP:  rd_addr = tslot_ff;
         default:   rd_addr = AW'(entry.beat.slot_index);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      hslot_in     = hslot_ff;
      tslot_in     = tslot_ff;
      cur_in       = issue ? entry : cur_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_in       = rsp_ff;
      gen_we       = 1'b0;
      gen_waddr    = hslot_ff;
      gen_wdata    = head_next;
      pay_we       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            gen_we    = 1'b1;
            gen_waddr = clr_ff;
            gen_wdata = 16'(clr_ff);
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (issue) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            unique case (cur_ff.beat.mode)
               MODE_PUSH: begin
                  if (gen_rdata == head_ff) begin
                     gen_we            = 1'b1;
                     pay_we            = 1'b1;
                     rsp_in.ok         = 1'b1;
                     rsp_in.out_slot   = 8'(hslot_ff);
                     rsp_in.out_ticket = head_next;
                     head_in           = head_next;
                     hslot_in = (head_ff == 16'hFFFF || hslot_ff == LAST) ? '0
                                                                         : hslot_ff + AW'(1);
                  end
               end
               MODE_POP: begin
                  if (gen_rdata == tail_next) begin
                     rsp_in.ok           = 1'b1;
                     rsp_in.out_slot     = 8'(tslot_ff);
                     rsp_in.out_ticket   = tail_next;
                     rsp_in.out_code     = pay_rdata[31:0];
                     rsp_in.out_argument = pay_rdata[63:32];
                     tail_in             = tail_next;
                     tslot_in = (tail_ff == 16'hFFFF || tslot_ff == LAST) ? '0
                                                                         : tslot_ff + AW'(1);
                  end
               end
               MODE_COMPLETE: begin
                  if (cur_ff.in_range) begin
                     gen_we    = 1'b1;
                     gen_waddr = cur_slot;
                     gen_wdata = cur_ff.beat.ticket + GEN_LAP;
                     rsp_in.ok = 1'b1;
                  end
               end
               MODE_QUERY: begin
                  if (cur_ff.in_range) begin
                     rsp_in.ok      = 1'b1;
                     rsp_in.is_done = (gen_rdata != cur_ff.beat.ticket);
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= 16'd0;
         tail_ff      <= 16'd0;
         hslot_ff     <= '0;
         tslot_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         hslot_ff     <= hslot_in;
         tslot_ff     <= tslot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   gttr_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (gen_waddr),
      .wr_data (gen_wdata),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (gen_rdata)
   );

   gttr_ram #(
      .WIDTH (64),
      .DEPTH (QUEUE_DEPTH)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (hslot_ff),
      .wr_data ({cur_ff.beat.task_argument, cur_ff.beat.task_code}),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (pay_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
